[rtl/i2cm_pkg.sv]
`default_nettype none

package i2cm_pkg;

   typedef logic [4:0] phase_type;

   localparam phase_type PH_IDLE    = 5'd0;
   localparam phase_type PH_START_A = 5'd1;
   localparam phase_type PH_START_B = 5'd2;
   localparam phase_type PH_W_SET   = 5'd3;
   localparam phase_type PH_W_HIGH  = 5'd4;
   localparam phase_type PH_W_FALL  = 5'd5;
   localparam phase_type PH_WA_SET  = 5'd6;
   localparam phase_type PH_WA_HIGH = 5'd7;
   localparam phase_type PH_WA_FALL = 5'd8;
   localparam phase_type PH_R_SET   = 5'd9;
   localparam phase_type PH_R_HIGH  = 5'd10;
   localparam phase_type PH_R_FALL  = 5'd11;
   localparam phase_type PH_RA_SET  = 5'd12;
   localparam phase_type PH_RA_HIGH = 5'd13;
   localparam phase_type PH_RA_FALL = 5'd14;
   localparam phase_type PH_RS_A    = 5'd15;
   localparam phase_type PH_RS_B    = 5'd16;
   localparam phase_type PH_STOP_A  = 5'd17;
   localparam phase_type PH_STOP_B  = 5'd18;
   localparam phase_type PH_STOP_C  = 5'd19;

   typedef logic [2:0] kind_type;

   localparam kind_type KIND_WRITE8     = 3'd0;
   localparam kind_type KIND_WRITE16    = 3'd1;
   localparam kind_type KIND_POINTER    = 3'd2;
   localparam kind_type KIND_READ8      = 3'd3;
   localparam kind_type KIND_READ16     = 3'd4;
   localparam kind_type KIND_CMD_READ16 = 3'd5;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   localparam logic [7:0] CMD_BASE = 8'b1000_0100;

   // line_drive: bit 0 pulls SCL, bit 1 pulls SDA
   localparam logic [1:0] LD_NONE = 2'b00;
   localparam logic [1:0] LD_SCL  = 2'b01;
   localparam logic [1:0] LD_SDA  = 2'b10;
   localparam logic [1:0] LD_BOTH = 2'b11;

   typedef enum logic [2:0] {
      IT_WRITE,
      IT_READ_ACK,
      IT_READ_NACK,
      IT_RESTART,
      IT_STOP
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic [7:0]    data;
   } item_type;

   function automatic item_type item_lookup(
      input kind_type    kind,
      input logic [2:0]  idx,
      input logic [6:0]  address,
      input logic [7:0]  reg_byte,
      input logic [15:0] value,
      input logic [2:0]  channel
   );
      item_type   res;
      logic [7:0] aw;
      logic [7:0] ar;
      aw       = {address, 1'b0};
      ar       = {address, 1'b1};
      res.kind = IT_STOP;
      res.data = 8'h00;
      case (kind)
         KIND_WRITE8: begin
            case (idx)
               3'd0: res = '{IT_WRITE, aw};
               3'd1: res = '{IT_WRITE, reg_byte};
               3'd2: res = '{IT_WRITE, value[7:0]};
               default: res = '{IT_STOP, 8'h00};
            endcase
         end
         KIND_WRITE16: begin
            case (idx)
               3'd0: res = '{IT_WRITE, aw};
               3'd1: res = '{IT_WRITE, reg_byte};
               3'd2: res = '{IT_WRITE, value[15:8]};
               3'd3: res = '{IT_WRITE, value[7:0]};
               default: res = '{IT_STOP, 8'h00};
            endcase
         end
         KIND_POINTER: begin
            case (idx)
               3'd0: res = '{IT_WRITE, aw};
               3'd1: res = '{IT_WRITE, reg_byte};
               default: res = '{IT_STOP, 8'h00};
            endcase
         end
         KIND_READ8: begin
            case (idx)
               3'd0: res = '{IT_WRITE, ar};
               3'd1: res = '{IT_READ_NACK, 8'h00};
               default: res = '{IT_STOP, 8'h00};
            endcase
         end
         KIND_READ16: begin
            case (idx)
               3'd0: res = '{IT_WRITE, ar};
               3'd1: res = '{IT_READ_ACK, 8'h00};
               3'd2: res = '{IT_READ_NACK, 8'h00};
               default: res = '{IT_STOP, 8'h00};
            endcase
         end
         KIND_CMD_READ16: begin
            case (idx)
               3'd0: res = '{IT_WRITE, aw};
               3'd1: res = '{IT_WRITE, CMD_BASE | {1'b0, channel, 4'b0000}};
               3'd2: res = '{IT_RESTART, 8'h00};
               3'd3: res = '{IT_WRITE, ar};
               3'd4: res = '{IT_READ_ACK, 8'h00};
               3'd5: res = '{IT_READ_NACK, 8'h00};
               default: res = '{IT_STOP, 8'h00};
            endcase
         end
         default: res = '{IT_STOP, 8'h00};
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

[rtl/i2cm_if.sv]
`default_nettype none

interface i2cm_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [2:0]  kind;
   logic [7:0]  reg_index;
   logic [15:0] write_value;
   logic [2:0]  channel;
   logic        sda_in;

   modport source (output valid, func, kind, reg_index, write_value, channel, sda_in,
                   input ready);
   modport sink (input valid, func, kind, reg_index, write_value, channel, sda_in,
                 output ready);
endinterface

interface i2cm_rsp_if;
   logic        valid;
   logic        ready;
   logic        scl_pull_low;
   logic        sda_pull_low;
   logic        busy_res;
   logic        done_res;
   logic [15:0] read_value;

   modport source (output valid, scl_pull_low, sda_pull_low, busy_res, done_res, read_value,
                   input ready);
   modport sink (input valid, scl_pull_low, sda_pull_low, busy_res, done_res, read_value,
                 output ready);
endinterface

`default_nettype wire

[rtl/i2c_master_transaction_engine.sv]
`default_nettype none

// Bit-banged open-drain I2C master. A start transaction (func 0) is taken only while idle
// and latches kind, register byte, write data and channel; each tick transaction (func 1)
// then moves the bus one line phase (start, address with R/W, bytes MSB first, ack slot,
// repeated start, stop), three ticks per bit. Every request transaction returns one
// response carrying the line drives, busy, done and the read accumulator, valid in the
// cycle after it is accepted. The sequencer step is combinational between the request
// and the response register. A request is taken whenever the response register is empty
// or its response leaves in the same cycle, so with the response side ready the block
// takes one transaction per clock. csr_write_data is latched as the 7-bit slave address
// on csr_write_enable; a write mid-transaction shows at the next address byte.

module i2c_master_transaction_engine (
   input  wire logic       clock,
   input  wire logic       reset,
   i2cm_req_if.sink        req_bus,
   i2cm_rsp_if.source      rsp_bus,
   input  wire logic       csr_write_enable,
   input  wire logic [6:0] csr_write_data
);
   import i2cm_pkg::*;

   logic [6:0]  device_address_ff;
   phase_type   phase_ff, phase_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [2:0]  byte_index_ff, byte_index_in;
   logic [7:0]  shift_byte_ff, shift_byte_in;
   logic [15:0] read_accum_ff, read_accum_in;
   kind_type    held_kind_ff, held_kind_in;
   logic [7:0]  held_reg_ff, held_reg_in;
   logic [15:0] held_value_ff, held_value_in;
   logic [2:0]  held_channel_ff, held_channel_in;
   logic [1:0]  line_drive_ff, line_drive_in;
   logic        done_in;

   logic        rsp_valid_ff;
   logic        scl_ff, sda_ff, busy_ff, done_ff;
   logic [15:0] read_value_ff;

   logic        req_accept;
   phase_type   phase_cur;
   logic [1:0]  line_cur;
   logic [3:0]  begin_idx;
   logic [3:0]  bit_count_inc;
   item_type    begin_item;
   item_type    ack_item;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;

   assign phase_cur = (phase_ff > PH_STOP_C) ? PH_IDLE : phase_ff;
   assign line_cur  = (phase_ff > PH_STOP_C) ? LD_NONE : line_drive_ff;

   assign begin_idx     = (phase_cur == PH_START_B) ? {1'b0, byte_index_ff}
                                                    : {1'b0, byte_index_ff} + 4'd1;
   assign bit_count_inc = bit_count_ff + 4'd1;

   assign begin_item = item_lookup(held_kind_ff, begin_idx[2:0], device_address_ff,
                                   held_reg_ff, held_value_ff, held_channel_ff);
   assign ack_item   = item_lookup(held_kind_ff, byte_index_ff, device_address_ff,
                                   held_reg_ff, held_value_ff, held_channel_ff);

   always_comb begin
      phase_in        = phase_cur;
      bit_count_in    = bit_count_ff;
      byte_index_in   = byte_index_ff;
      shift_byte_in   = shift_byte_ff;
      read_accum_in   = read_accum_ff;
      held_kind_in    = held_kind_ff;
      held_reg_in     = held_reg_ff;
      held_value_in   = held_value_ff;
      held_channel_in = held_channel_ff;
      line_drive_in   = line_cur;
      done_in         = 1'b0;
      if (req_bus.func == FUNC_START) begin
         if (phase_cur == PH_IDLE && req_bus.kind <= KIND_CMD_READ16) begin
            held_kind_in    = req_bus.kind;
            held_reg_in     = req_bus.reg_index;
            held_value_in   = req_bus.write_value;
            held_channel_in = req_bus.channel;
            bit_count_in    = '0;
            byte_index_in   = '0;
            shift_byte_in   = '0;
            read_accum_in   = '0;
            line_drive_in   = LD_NONE;
            phase_in        = PH_START_A;
         end
      end else begin
         unique case (phase_cur) inside
            PH_START_A: begin
               line_drive_in = LD_SDA;
               phase_in      = PH_START_B;
            end
            PH_W_SET: begin
               line_drive_in = shift_byte_ff[7] ? LD_SCL : LD_BOTH;
               phase_in      = PH_W_HIGH;
            end
            PH_W_HIGH: begin
               line_drive_in = line_cur & LD_SDA;
               phase_in      = PH_W_FALL;
            end
            PH_W_FALL: begin
               line_drive_in = line_cur | LD_SCL;
               shift_byte_in = {shift_byte_ff[6:0], 1'b0};
               if (bit_count_inc >= 4'd8) begin
                  bit_count_in = '0;
                  phase_in     = PH_WA_SET;
               end else begin
                  bit_count_in = bit_count_inc;
                  phase_in     = PH_W_SET;
               end
            end
            PH_WA_SET: begin
               line_drive_in = LD_SCL;
               phase_in      = PH_WA_HIGH;
            end
            PH_WA_HIGH: begin
               line_drive_in = LD_NONE;
               phase_in      = PH_WA_FALL;
            end
            PH_R_SET: begin
               line_drive_in = LD_SCL;
               phase_in      = PH_R_HIGH;
            end
            PH_R_HIGH: begin
               line_drive_in = LD_NONE;
               read_accum_in = {read_accum_ff[14:0], req_bus.sda_in};
               phase_in      = PH_R_FALL;
            end
            PH_R_FALL: begin
               line_drive_in = LD_SCL;
               if (bit_count_inc >= 4'd8) begin
                  bit_count_in = '0;
                  phase_in     = PH_RA_SET;
               end else begin
                  bit_count_in = bit_count_inc;
                  phase_in     = PH_R_SET;
               end
            end
            PH_RA_SET: begin
               line_drive_in = (ack_item.kind == IT_READ_ACK) ? LD_BOTH : LD_SCL;
               phase_in      = PH_RA_HIGH;
            end
            PH_RA_HIGH: begin
               line_drive_in = line_cur & LD_SDA;
               phase_in      = PH_RA_FALL;
            end
            PH_RS_A: begin
               line_drive_in = LD_SCL;
               phase_in      = PH_RS_B;
            end
            PH_RS_B: begin
               line_drive_in = LD_NONE;
               phase_in      = PH_START_A;
            end
            PH_STOP_A: begin
               line_drive_in = LD_BOTH;
               phase_in      = PH_STOP_B;
            end
            PH_STOP_B: begin
               line_drive_in = LD_SDA;
               phase_in      = PH_STOP_C;
            end
            PH_STOP_C: begin
               line_drive_in = LD_NONE;
               phase_in      = PH_IDLE;
               done_in       = 1'b1;
            end
            PH_START_B, PH_WA_FALL, PH_RA_FALL: begin
               case (phase_cur)
                  PH_START_B: line_drive_in = LD_BOTH;
                  PH_WA_FALL: line_drive_in = LD_SCL;
                  default:    line_drive_in = line_cur | LD_SCL;
               endcase
               if (begin_idx[3]) begin
                  phase_in = PH_STOP_A;
               end else begin
                  byte_index_in = begin_idx[2:0];
                  bit_count_in  = '0;
                  case (begin_item.kind) inside
                     IT_WRITE: begin
                        shift_byte_in = begin_item.data;
                        phase_in      = PH_W_SET;
                     end
                     IT_READ_ACK, IT_READ_NACK: begin
                        phase_in = PH_R_SET;
                     end
                     IT_RESTART: begin
                        byte_index_in = begin_idx[2:0] + 3'd1;
                        phase_in      = PH_RS_A;
                     end
                     default: begin
                        phase_in = PH_STOP_A;
                     end
                  endcase
               end
            end
            default: begin
               line_drive_in = LD_NONE;
               phase_in      = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= '0;
      end else if (csr_write_enable) begin
         device_address_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         bit_count_ff    <= '0;
         byte_index_ff   <= '0;
         shift_byte_ff   <= '0;
         read_accum_ff   <= '0;
         held_kind_ff    <= '0;
         held_reg_ff     <= '0;
         held_value_ff   <= '0;
         held_channel_ff <= '0;
         line_drive_ff   <= LD_NONE;
      end else if (req_accept) begin
         phase_ff        <= phase_in;
         bit_count_ff    <= bit_count_in;
         byte_index_ff   <= byte_index_in;
         shift_byte_ff   <= shift_byte_in;
         read_accum_ff   <= read_accum_in;
         held_kind_ff    <= held_kind_in;
         held_reg_ff     <= held_reg_in;
         held_value_ff   <= held_value_in;
         held_channel_ff <= held_channel_in;
         line_drive_ff   <= line_drive_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         scl_ff        <= line_drive_in[0];
         sda_ff        <= line_drive_in[1];
         busy_ff       <= (phase_in != PH_IDLE);
         done_ff       <= done_in;
         read_value_ff <= read_accum_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.scl_pull_low = scl_ff;
   assign rsp_bus.sda_pull_low = sda_ff;
   assign rsp_bus.busy_res     = busy_ff;
   assign rsp_bus.done_res     = done_ff;
   assign rsp_bus.read_value   = read_value_ff;

`ifndef SYNTHESIS
   a_start_taken: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_bus.func == FUNC_START && phase_cur == PH_IDLE &&
      req_bus.kind <= KIND_CMD_READ16 |=> phase_ff == PH_START_A)
      else $error("start transaction not taken while idle");

   a_accum_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(read_accum_ff))
      else $error("read accumulator moved without a transaction");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept && done_in |=> phase_ff == PH_IDLE && line_drive_ff == LD_NONE)
      else $error("stop finished with bus not released");
`endif

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;
   import i2cm_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 20;
   localparam int SDA_LOW        = 0;
   localparam int SDA_HIGH       = 1;
   localparam int SDA_RANDOM     = 2;

   typedef struct {
      logic        scl;
      logic        sda;
      logic        busy;
      logic        done;
      logic [15:0] rd;
   } bus_view_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write_enable;
   logic [6:0] csr_write_data;

   i2cm_req_if req_if ();
   i2cm_rsp_if rsp_if ();

   i2c_master_transaction_engine dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_if),
      .rsp_bus          (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // bus model state
   logic [6:0]  dev_addr;
   phase_type   ph;
   logic [3:0]  bit_cnt;
   logic [2:0]  byte_idx;
   logic [7:0]  shifter;
   logic [15:0] accum;
   kind_type    h_kind;
   logic [7:0]  h_reg;
   logic [15:0] h_val;
   logic [2:0]  h_chan;
   logic [1:0]  drive;

   bus_view_type line_expect[$];
   int           fail_count    = 0;
   int           requests_sent = 0;
   int           idle_cycles   = 0;
   bit           quiet         = 1'b0;

   function automatic void reset_model();
      dev_addr = '0;
      ph       = PH_IDLE;
      bit_cnt  = '0;
      byte_idx = '0;
      shifter  = '0;
      accum    = '0;
      h_kind   = KIND_WRITE8;
      h_reg    = '0;
      h_val    = '0;
      h_chan   = '0;
      drive    = LD_NONE;
   endfunction

   // what the held transaction puts on the bus at sequence slot idx
   function automatic item_kind_type slot_item(input int idx, output logic [7:0] data);
      item_kind_type seq[8];
      logic [7:0]    bytes[8];
      for (int i = 0; i < 8; i++) begin
         seq[i]   = IT_STOP;
         bytes[i] = 8'h00;
      end
      bytes[0] = {dev_addr, 1'b0};
      seq[0]   = IT_WRITE;
      case (h_kind)
         KIND_WRITE8: begin
            seq[1] = IT_WRITE; bytes[1] = h_reg;
            seq[2] = IT_WRITE; bytes[2] = h_val[7:0];
         end
         KIND_WRITE16: begin
            seq[1] = IT_WRITE; bytes[1] = h_reg;
            seq[2] = IT_WRITE; bytes[2] = h_val[15:8];
            seq[3] = IT_WRITE; bytes[3] = h_val[7:0];
         end
         KIND_POINTER: begin
            seq[1] = IT_WRITE; bytes[1] = h_reg;
         end
         KIND_READ8: begin
            bytes[0] = {dev_addr, 1'b1};
            seq[1]   = IT_READ_NACK;
         end
         KIND_READ16: begin
            bytes[0] = {dev_addr, 1'b1};
            seq[1]   = IT_READ_ACK;
            seq[2]   = IT_READ_NACK;
         end
         KIND_CMD_READ16: begin
            seq[1] = IT_WRITE; bytes[1] = CMD_BASE | {1'b0, h_chan, 4'b0000};
            seq[2] = IT_RESTART;
            seq[3] = IT_WRITE; bytes[3] = {dev_addr, 1'b1};
            seq[4] = IT_READ_ACK;
            seq[5] = IT_READ_NACK;
         end
         default: seq[0] = IT_STOP;
      endcase
      data = 8'h00;
      if (idx > 7) return IT_STOP;
      data = bytes[idx];
      return seq[idx];
   endfunction

   function automatic void next_slot(input int idx);
      logic [7:0]    b;
      item_kind_type it;
      if (idx > 7) begin
         ph = PH_STOP_A;
         return;
      end
      byte_idx = idx[2:0];
      it       = slot_item(idx, b);
      bit_cnt  = '0;
      case (it)
         IT_WRITE: begin
            shifter = b;
            ph      = PH_W_SET;
         end
         IT_READ_ACK, IT_READ_NACK: ph = PH_R_SET;
         IT_RESTART: begin
            byte_idx = 3'(idx + 1);
            ph       = PH_RS_A;
         end
         default: ph = PH_STOP_A;
      endcase
   endfunction

   function automatic void predict_phase(input logic func, input kind_type kind,
                                         input logic [7:0] reg_byte, input logic [15:0] value,
                                         input logic [2:0] chan, input logic sda);
      logic          done;
      logic [7:0]    b;
      item_kind_type it;
      bus_view_type  v;
      done = 1'b0;
      if (func == FUNC_START) begin
         if (ph == PH_IDLE && kind <= KIND_CMD_READ16) begin
            h_kind   = kind;
            h_reg    = reg_byte;
            h_val    = value;
            h_chan   = chan;
            bit_cnt  = '0;
            byte_idx = '0;
            shifter  = '0;
            accum    = '0;
            drive    = LD_NONE;
            ph       = PH_START_A;
         end
      end else begin
         case (ph)
            PH_START_A: begin
               drive = LD_SDA;
               ph    = PH_START_B;
            end
            PH_START_B: begin
               drive = LD_BOTH;
               next_slot(int'(byte_idx));
            end
            PH_W_SET: begin
               drive = LD_SCL | (shifter[7] ? LD_NONE : LD_SDA);
               ph    = PH_W_HIGH;
            end
            PH_W_HIGH: begin
               drive = drive & LD_SDA;
               ph    = PH_W_FALL;
            end
            PH_W_FALL: begin
               drive   = drive | LD_SCL;
               shifter = shifter << 1;
               bit_cnt = bit_cnt + 4'd1;
               if (bit_cnt >= 4'd8) begin
                  bit_cnt = '0;
                  ph      = PH_WA_SET;
               end else begin
                  ph = PH_W_SET;
               end
            end
            PH_WA_SET: begin
               drive = LD_SCL;
               ph    = PH_WA_HIGH;
            end
            PH_WA_HIGH: begin
               drive = LD_NONE;
               ph    = PH_WA_FALL;
            end
            PH_WA_FALL: begin
               drive = LD_SCL;
               next_slot(int'(byte_idx) + 1);
            end
            PH_R_SET: begin
               drive = LD_SCL;
               ph    = PH_R_HIGH;
            end
            PH_R_HIGH: begin
               drive = LD_NONE;
               accum = {accum[14:0], sda};
               ph    = PH_R_FALL;
            end
            PH_R_FALL: begin
               drive   = LD_SCL;
               bit_cnt = bit_cnt + 4'd1;
               if (bit_cnt >= 4'd8) begin
                  bit_cnt = '0;
                  ph      = PH_RA_SET;
               end else begin
                  ph = PH_R_SET;
               end
            end
            PH_RA_SET: begin
               it    = slot_item(int'(byte_idx), b);
               drive = LD_SCL | ((it == IT_READ_ACK) ? LD_SDA : LD_NONE);
               ph    = PH_RA_HIGH;
            end
            PH_RA_HIGH: begin
               drive = drive & LD_SDA;
               ph    = PH_RA_FALL;
            end
            PH_RA_FALL: begin
               drive = drive | LD_SCL;
               next_slot(int'(byte_idx) + 1);
            end
            PH_RS_A: begin
               drive = LD_SCL;
               ph    = PH_RS_B;
            end
            PH_RS_B: begin
               drive = LD_NONE;
               ph    = PH_START_A;
            end
            PH_STOP_A: begin
               drive = LD_BOTH;
               ph    = PH_STOP_B;
            end
            PH_STOP_B: begin
               drive = LD_SDA;
               ph    = PH_STOP_C;
            end
            PH_STOP_C: begin
               drive = LD_NONE;
               ph    = PH_IDLE;
               done  = 1'b1;
            end
            default: begin
               drive = LD_NONE;
               ph    = PH_IDLE;
            end
         endcase
      end
      v.scl  = drive[0];
      v.sda  = drive[1];
      v.busy = (ph != PH_IDLE);
      v.done = done;
      v.rd   = accum;
      line_expect.push_back(v);
   endfunction

   // stimulus, called just after a rising edge
   task automatic send_request(input logic func, input kind_type kind,
                               input logic [7:0] reg_byte, input logic [15:0] value,
                               input logic [2:0] chan, input logic sda);
      if (!quiet) begin
         while ($urandom_range(99) < 14) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_if.valid       <= 1'b1;
      req_if.func        <= func;
      req_if.kind        <= kind;
      req_if.reg_index   <= reg_byte;
      req_if.write_value <= value;
      req_if.channel     <= chan;
      req_if.sda_in      <= sda;
      do @(posedge clock); while (!req_if.ready);
      predict_phase(func, kind, reg_byte, value, chan, sda);
      requests_sent++;
   endtask

   task automatic tick(input logic sda);
      send_request(FUNC_TICK, kind_type'($urandom_range(7)), 8'($urandom), 16'($urandom),
                   3'($urandom), sda);
   endtask

   task automatic start_transfer(input kind_type kind, input logic [7:0] reg_byte,
                                 input logic [15:0] value, input logic [2:0] chan);
      send_request(FUNC_START, kind, reg_byte, value, chan, 1'($urandom_range(1)));
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (line_expect.size() != 0);
   endtask

   task automatic set_address(input logic [6:0] addr);
      csr_write_enable <= 1'b1;
      csr_write_data   <= addr;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      dev_addr = addr;
   endtask

   function automatic logic [6:0] pick_address();
      case ($urandom_range(3))
         0: return 7'h00;
         1: return 7'h7F;
         default: return 7'($urandom_range(127));
      endcase
   endfunction

   function automatic logic pick_sda(input int mode);
      if (mode == SDA_LOW) return 1'b0;
      if (mode == SDA_HIGH) return 1'b1;
      return 1'($urandom_range(1));
   endfunction

   task automatic run_to_stop(input int mode, input bit noisy);
      int guard;
      guard = 0;
      while (ph != PH_IDLE && guard < 1000) begin
         guard++;
         if (noisy && $urandom_range(99) < 4) begin
            start_transfer(kind_type'($urandom_range(7)), 8'($urandom), 16'($urandom),
                           3'($urandom));
         end else if (noisy && $urandom_range(199) == 0) begin
            drain_results();
            set_address(pick_address());
         end else begin
            tick(pick_sda(mode));
         end
      end
   endtask

   task automatic test_idle_cases();
      tick(1'b0);
      tick(1'b1);
      start_transfer(kind_type'(6), 8'hFF, 16'hFFFF, 3'd7);
      start_transfer(kind_type'(7), 8'h00, 16'h0000, 3'd0);
      tick(1'b1);
   endtask

   task automatic test_each_kind();
      start_transfer(KIND_WRITE8, 8'h00, 16'h0000, 3'd0);
      run_to_stop(SDA_RANDOM, 0);
      drain_results();
      set_address(7'h7F);
      start_transfer(KIND_WRITE16, 8'hFF, 16'hFFFF, 3'd7);
      run_to_stop(SDA_RANDOM, 0);
      start_transfer(KIND_POINTER, 8'hA5, 16'h5A5A, 3'd5);
      run_to_stop(SDA_RANDOM, 0);
      start_transfer(KIND_READ8, 8'h00, 16'h0000, 3'd0);
      run_to_stop(SDA_HIGH, 0);
      start_transfer(KIND_READ16, 8'hFF, 16'hFFFF, 3'd7);
      run_to_stop(SDA_LOW, 0);
      start_transfer(KIND_READ16, 8'h81, 16'h8001, 3'd1);
      run_to_stop(SDA_HIGH, 0);
      start_transfer(KIND_CMD_READ16, 8'h00, 16'h0000, 3'd7);
      run_to_stop(SDA_RANDOM, 0);
      start_transfer(KIND_CMD_READ16, 8'hFF, 16'hFFFF, 3'd0);
      run_to_stop(SDA_HIGH, 0);
      start_transfer(KIND_WRITE8, 8'h7E, 16'hFF00, 3'd3);
      run_to_stop(SDA_RANDOM, 0);
   endtask

   task automatic test_start_while_busy();
      start_transfer(KIND_WRITE16, 8'h3C, 16'h1234, 3'd2);
      repeat (5) tick(1'b1);
      start_transfer(KIND_READ8, 8'hC3, 16'hEDCB, 3'd5);
      tick(1'b0);
      start_transfer(KIND_WRITE8, 8'h11, 16'h2222, 3'd6);
      run_to_stop(SDA_RANDOM, 0);
   endtask

   // new address must only show at the read address byte after the repeated start
   task automatic test_address_switch();
      int guard;
      drain_results();
      set_address(7'h55);
      start_transfer(KIND_CMD_READ16, 8'h42, 16'h4321, 3'd3);
      guard = 0;
      while (ph != PH_RS_A && guard < 1000) begin
         guard++;
         tick(1'($urandom_range(1)));
      end
      drain_results();
      set_address(7'h2A);
      run_to_stop(SDA_RANDOM, 0);
   endtask

   task automatic test_random_traffic(input int n);
      int goal;
      int txn;
      int mode;
      goal = requests_sent + n;
      txn  = 0;
      while (requests_sent < goal) begin
         txn++;
         quiet = (txn <= 2);
         if (txn == 3) drain_results();
         if ($urandom_range(3) == 0) begin
            drain_results();
            set_address(pick_address());
         end
         case ($urandom_range(9))
            0: tick(1'($urandom_range(1)));
            1: start_transfer(kind_type'($urandom_range(6, 7)), 8'($urandom), 16'($urandom),
                              3'($urandom));
            default: ;
         endcase
         mode = ($urandom_range(3) == 0) ? $urandom_range(1) : SDA_RANDOM;
         start_transfer(kind_type'($urandom_range(5)), 8'($urandom), 16'($urandom),
                        3'($urandom));
         run_to_stop(mode, 1);
      end
      quiet = 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_if.ready <= quiet || ($urandom_range(99) >= 14);
   end

   always @(posedge clock) begin : check_results
      bus_view_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (line_expect.size() == 0) begin
               $error("response with no transaction outstanding");
               fail_count++;
            end else begin
               want = line_expect.pop_front();
               if (rsp_if.scl_pull_low !== want.scl) begin
                  $error("scl_pull_low: expected %0d, actual %0d", want.scl,
                         rsp_if.scl_pull_low);
                  fail_count++;
               end
               if (rsp_if.sda_pull_low !== want.sda) begin
                  $error("sda_pull_low: expected %0d, actual %0d", want.sda,
                         rsp_if.sda_pull_low);
                  fail_count++;
               end
               if (rsp_if.busy_res !== want.busy) begin
                  $error("busy_res: expected %0d, actual %0d", want.busy, rsp_if.busy_res);
                  fail_count++;
               end
               if (rsp_if.done_res !== want.done) begin
                  $error("done_res: expected %0d, actual %0d", want.done, rsp_if.done_res);
                  fail_count++;
               end
               if (rsp_if.read_value !== want.rd) begin
                  $error("read_value: expected %04h, actual %04h", want.rd,
                         rsp_if.read_value);
                  fail_count++;
               end
            end
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   initial begin
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_write_data     = '0;
      rsp_if.ready       = 1'b0;
      req_if.valid       = 1'b0;
      req_if.func        = FUNC_TICK;
      req_if.kind        = KIND_WRITE8;
      req_if.reg_index   = '0;
      req_if.write_value = '0;
      req_if.channel     = '0;
      req_if.sda_in      = 1'b0;
      reset_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_idle_cases();
      test_each_kind();
      test_start_while_busy();
      test_address_switch();
      test_random_traffic(420);

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (line_expect.size() != 0) begin
         $error("%0d responses never arrived", line_expect.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
